### src/tcds_pkg.sv
package tcds_pkg;

   // Deque size and the widths that follow from it.
   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Request codes carried in req_type.
   localparam logic [1:0] REQ_NONE   = 2'd0;
   localparam logic [1:0] REQ_NORMAL = 2'd1;
   localparam logic [1:0] REQ_URGENT = 2'd2;

   // Shift operations broadcast along the row of cells.
   localparam logic [1:0] SHIFT_HOLD  = 2'd0;
   localparam logic [1:0] SHIFT_RIGHT = 2'd1;
   localparam logic [1:0] SHIFT_LEFT  = 2'd2;

   // One input transaction.
   typedef struct packed {
      logic [1:0]  req_type;
      logic [7:0]  class_id;
      logic [15:0] requester_id;
      logic [7:0]  service_minutes;
   } tcds_req_type;

   // One result transaction.
   typedef struct packed {
      logic        busy_res;
      logic        is_urgent;
      logic [7:0]  served_class;
      logic [15:0] served_requester;
      logic [7:0]  time_left;
      logic        dropped;
   } tcds_rsp_type;

   // One waiting deque entry.
   typedef struct packed {
      logic        urgent;
      logic [7:0]  class_id;
      logic [15:0] requester_id;
      logic [7:0]  service_minutes;
   } tcds_entry_type;

   // Per-cell control: shared shift operation plus a local load strobe.
   typedef struct packed {
      logic [1:0] op;
      logic       load;
   } tcds_cell_ctl_type;

endpackage

### src/tcds_cell.sv
module tcds_cell (
   input  logic                       clock,
   input  tcds_pkg::tcds_entry_type   from_left,
   input  tcds_pkg::tcds_entry_type   from_right,
   input  tcds_pkg::tcds_entry_type   new_entry,
   input  tcds_pkg::tcds_cell_ctl_type ctl,
   output tcds_pkg::tcds_entry_type   entry_out
);
   import tcds_pkg::*;

   tcds_entry_type entry_ff;
   tcds_entry_type entry_in;

   // A load wins over the shift; otherwise take a neighbor or hold.
   always_comb begin
      entry_in = entry_ff;
      if (ctl.load) begin
         entry_in = new_entry;
      end else begin
         unique case (ctl.op)
            SHIFT_RIGHT: entry_in = from_left;
            SHIFT_LEFT:  entry_in = from_right;
            default:     entry_in = entry_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;

endmodule

### src/two_class_deque_service_scheduler_core.sv
// Two-class deque service scheduler.
// Input channel req_valid/req_ready/req_data carries one tick per transaction:
// no request, a normal request (joins the back of the deque) or an urgent
// request (pushed on the front). Result channel rsp_valid/rsp_ready/rsp_data
// returns exactly one result per accepted tick: the entry in service and its
// time left before this tick's decrement, and a flag for a request dropped
// because the deque was full.
// The deque is a row of cells, front at cell 0, that shift together by one
// place, load one slot, or both, per tick. rsp_valid rises in the cycle after
// acceptance; throughput is one transaction per cycle while rsp_ready stays
// high, set by the single result register.
// When the receiver stalls, the result register holds its transaction and
// req_ready goes low until it is taken.
// Reset empties the deque, idles the server and clears rsp_valid; the cell
// contents are not cleared, as the entry count tells which cells are live.
module two_class_deque_service_scheduler_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tcds_pkg::tcds_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tcds_pkg::tcds_rsp_type rsp_data
);
   import tcds_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       rem_ff, rem_in;
   logic             cur_urgent_ff, cur_urgent_in;
   logic [7:0]       cur_class_ff, cur_class_in;
   logic [15:0]      cur_requester_ff, cur_requester_in;
   logic             rsp_valid_ff, rsp_valid_in;
   tcds_rsp_type     rsp_ff, rsp_in;

   tcds_entry_type    cell_q [QUEUE_DEPTH];
   tcds_cell_ctl_type cell_ctl [QUEUE_DEPTH];
   tcds_entry_type    new_entry;

   logic             accept;
   logic             is_req, is_urgent_req, full, push, push_head, push_tail, pop;
   logic [CNT_W-1:0] count_after_push;
   logic [1:0]       shift_op;
   logic             load_en;
   logic [IDX_W-1:0] tail_idx;
   tcds_entry_type   pop_word;
   logic [7:0]       rem_eff;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;

   assign new_entry.urgent          = (req_data.req_type == REQ_URGENT);
   assign new_entry.class_id        = req_data.class_id;
   assign new_entry.requester_id    = req_data.requester_id;
   assign new_entry.service_minutes = req_data.service_minutes;

   // Arrival decode and the server's decision to take the front entry.
   always_comb begin
      is_req           = (req_data.req_type == REQ_NORMAL) ||
                         (req_data.req_type == REQ_URGENT);
      is_urgent_req    = (req_data.req_type == REQ_URGENT);
      full             = (count_ff == CNT_W'(QUEUE_DEPTH));
      push             = accept && is_req && !full;
      push_head        = push && is_urgent_req;
      push_tail        = push && !is_urgent_req;
      count_after_push = count_ff + CNT_W'(push);
      pop              = accept && (rem_ff == 8'd0) && (count_after_push != '0);
   end

   // Shift and load control for the row of cells.
   always_comb begin
      shift_op = SHIFT_HOLD;
      load_en  = 1'b0;
      tail_idx = count_ff[IDX_W-1:0];
      pop_word = cell_q[0];
      if (push_head) begin
         // An urgent arrival taken at once never enters the row.
         if (pop) begin
            pop_word = new_entry;
         end else begin
            shift_op = SHIFT_RIGHT;
         end
      end else if (push_tail) begin
         if (pop) begin
            if (count_ff == '0) begin
               pop_word = new_entry;
            end else begin
               shift_op = SHIFT_LEFT;
               load_en  = 1'b1;
               tail_idx = IDX_W'(count_ff - CNT_W'(1));
            end
         end else begin
            load_en = 1'b1;
         end
      end else if (pop) begin
         shift_op = SHIFT_LEFT;
      end
   end

   // Row of cells, front at index 0.
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      tcds_entry_type left_in;
      tcds_entry_type right_in;

      if (i == 0) begin : g_first
         assign left_in = new_entry;
      end else begin : g_mid_l
         assign left_in = cell_q[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_in = '0;
      end else begin : g_mid_r
         assign right_in = cell_q[i+1];
      end

      assign cell_ctl[i].op   = shift_op;
      assign cell_ctl[i].load = load_en && (tail_idx == IDX_W'(i));

      tcds_cell u_cell (
         .clock      (clock),
         .from_left  (left_in),
         .from_right (right_in),
         .new_entry  (new_entry),
         .ctl        (cell_ctl[i]),
         .entry_out  (cell_q[i])
      );
   end

   // Server update and result formation.
   always_comb begin
      count_in         = count_ff;
      rem_in           = rem_ff;
      cur_urgent_in    = cur_urgent_ff;
      cur_class_in     = cur_class_ff;
      cur_requester_in = cur_requester_ff;
      rsp_in           = rsp_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rem_eff          = rem_ff;
      if (accept) begin
         count_in = count_after_push - CNT_W'(pop);
         if (pop) begin
            cur_urgent_in    = pop_word.urgent;
            cur_class_in     = pop_word.class_id;
            cur_requester_in = pop_word.requester_id;
            rem_eff          = pop_word.service_minutes;
         end
         rsp_in         = '0;
         rsp_in.dropped = is_req && full;
         if (rem_eff != 8'd0) begin
            rsp_in.busy_res         = 1'b1;
            rsp_in.is_urgent        = cur_urgent_in;
            rsp_in.served_class     = cur_class_in;
            rsp_in.served_requester = cur_requester_in;
            rsp_in.time_left        = rem_eff;
            rem_in                  = rem_eff - 8'd1;
         end else begin
            rem_in = rem_eff;
         end
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff         <= '0;
         rem_ff           <= '0;
         cur_urgent_ff    <= 1'b0;
         cur_class_ff     <= '0;
         cur_requester_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         count_ff         <= count_in;
         rem_ff           <= rem_in;
         cur_urgent_ff    <= cur_urgent_in;
         cur_class_ff     <= cur_class_in;
         cur_requester_ff <= cur_requester_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
